### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL; compiled out by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising edge, skipped while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Property checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### sv/ctae_pkg.sv
// ----------------------------------------------------------------------------
// ctae_pkg
// Shared types, tag and escape tables for the colour tag converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ctae_pkg;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;

    // Tag spellings, one row per tag; the last row is unused.
    localparam logic [7:0] TAG_TEXT [0:7][0:8] = '{
        '{CH_LBRACE, "r", "e", "d", CH_RBRACE, 8'h00, 8'h00, 8'h00, 8'h00},
        '{CH_LBRACE, "g", "r", "e", "e", "n", CH_RBRACE, 8'h00, 8'h00},
        '{CH_LBRACE, "y", "e", "l", "l", "o", "w", CH_RBRACE, 8'h00},
        '{CH_LBRACE, "b", "l", "u", "e", CH_RBRACE, 8'h00, 8'h00, 8'h00},
        '{CH_LBRACE, "m", "a", "g", "n", "e", "t", "a", CH_RBRACE},
        '{CH_LBRACE, "c", "y", "a", "n", CH_RBRACE, 8'h00, 8'h00, 8'h00},
        '{CH_LBRACE, "e", "o", "c", CH_RBRACE, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] TAG_LEN [0:7] = '{
        4'd5, 4'd7, 4'd8, 4'd6, 4'd9, 4'd6, 4'd5, 4'd0
    };
    localparam logic [2:0] TAG_COUNT = 3'd7;

    // Escape sequences that replace each tag.
    localparam logic [7:0] ESC_TEXT [0:7][0:4] = '{
        '{CH_ESC, CH_LBRACK, "3", "1", "m"},
        '{CH_ESC, CH_LBRACK, "3", "2", "m"},
        '{CH_ESC, CH_LBRACK, "3", "3", "m"},
        '{CH_ESC, CH_LBRACK, "3", "4", "m"},
        '{CH_ESC, CH_LBRACK, "3", "5", "m"},
        '{CH_ESC, CH_LBRACK, "3", "6", "m"},
        '{CH_ESC, CH_LBRACK, "0", "m", 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] ESC_LEN [0:7] = '{
        4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd4, 4'd0
    };

    // What follows the held tag prefix in one command.
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_BYTE,
        TAIL_ESC
    } t_tail;

    // One command from the classifier to the emitter.
    typedef struct packed {
        logic [2:0] tag;
        logic [3:0] prefix_len;
        t_tail      tail;
        logic [7:0] tail_byte;
        logic [3:0] last_idx;
        logic       eos;
    } t_cmd;

    function automatic logic [7:0] tag_char(input logic [2:0] tag, input logic [3:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (pos <= 4'd8) begin
            ch = TAG_TEXT[tag][pos];
        end
        return ch;
    endfunction

    function automatic logic [7:0] esc_char(input logic [2:0] tag, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        if (pos <= 3'd4) begin
            ch = ESC_TEXT[tag][pos];
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

### sv/ctae_front.sv
// ----------------------------------------------------------------------------
// ctae_front
// Tag matcher: tracks the partial tag and turns each input byte into at most
// one emit command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ctae_front
    import ctae_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output      logic       o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  wire logic       i_s_tlast,   // end_of_string
    output      logic       o_q_valid,
    input  wire logic       i_q_ready,
    output      t_cmd       o_q_cmd,
    output      logic       o_idle
);

    logic [2:0] r_cand;
    logic [3:0] r_mc;
    logic [2:0] n_cand;
    logic [3:0] n_mc;
    logic       w_accept;
    logic       w_hit;
    logic [2:0] w_hit_tag;
    logic [3:0] w_mc_inc;
    logic [3:0] w_tail_len;
    t_cmd       w_cmd;

    assign w_accept = i_s_tvalid && i_q_ready;
    assign w_mc_inc = r_mc + 4'd1;

    // Look up the tag whose second character matches the byte.
    always_comb begin
        w_hit     = 1'b0;
        w_hit_tag = 3'd0;
        for (int t = 0; t < 7; t++) begin
            if (!w_hit && TAG_TEXT[t][1] == i_s_tdata) begin
                w_hit     = 1'b1;
                w_hit_tag = 3'(t);
            end
        end
    end

    // Classify the byte against the current match and build the command.
    always_comb begin
        n_cand          = r_cand;
        n_mc            = r_mc;
        w_cmd.tag       = r_cand;
        w_cmd.prefix_len = 4'd0;
        w_cmd.tail      = TAIL_NONE;
        w_cmd.tail_byte = i_s_tdata;
        w_cmd.eos       = i_s_tlast;

        if (r_mc == 4'd0) begin
            if (i_s_tdata == CH_LBRACE) begin
                n_mc = 4'd1;
            end else begin
                w_cmd.tail = TAIL_BYTE;
            end
        end else if (r_mc == 4'd1) begin
            if (w_hit) begin
                n_cand = w_hit_tag;
                n_mc   = 4'd2;
            end else begin
                w_cmd.prefix_len = 4'd1;
                if (i_s_tdata == CH_LBRACE) begin
                    n_mc = 4'd1;
                end else begin
                    n_mc       = 4'd0;
                    w_cmd.tail = TAIL_BYTE;
                end
            end
        end else begin
            if (r_mc < TAG_LEN[r_cand] && tag_char(r_cand, r_mc) == i_s_tdata) begin
                if (w_mc_inc == TAG_LEN[r_cand]) begin
                    w_cmd.tail = TAIL_ESC;
                    n_mc       = 4'd0;
                end else begin
                    n_mc = w_mc_inc;
                end
            end else begin
                w_cmd.prefix_len = r_mc;
                if (i_s_tdata == CH_LBRACE) begin
                    n_mc = 4'd1;
                end else begin
                    n_mc       = 4'd0;
                    w_cmd.tail = TAIL_BYTE;
                end
            end
        end

        // End of string flushes whatever is still held.
        if (i_s_tlast) begin
            if (n_mc == 4'd1) begin
                w_cmd.tail      = TAIL_BYTE;
                w_cmd.tail_byte = CH_LBRACE;
            end else if (n_mc != 4'd0) begin
                w_cmd.prefix_len = n_mc;
                w_cmd.tag        = n_cand;
            end
            n_mc   = 4'd0;
            n_cand = 3'd0;
        end

        unique case (w_cmd.tail)
            TAIL_BYTE: w_tail_len = 4'd1;
            TAIL_ESC:  w_tail_len = ESC_LEN[w_cmd.tag];
            default:   w_tail_len = 4'd0;
        endcase
        w_cmd.last_idx = w_cmd.prefix_len + w_tail_len - 4'd1;
    end

    // Match state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= 3'd0;
            r_mc   <= 4'd0;
        end else if (w_accept) begin
            r_cand <= (n_cand < TAG_COUNT) ? n_cand : 3'd0;
            r_mc   <= n_mc;
        end
    end

    assign o_s_tready = i_q_ready;
    assign o_q_valid  = i_s_tvalid && (w_cmd.prefix_len != 4'd0 || w_cmd.tail != TAIL_NONE);
    assign o_q_cmd    = w_cmd;
    assign o_idle     = (r_mc == 4'd0);

endmodule

`default_nettype wire

### sv/ctae_fifo.sv
// ----------------------------------------------------------------------------
// ctae_fifo
// Two-entry command queue between the matcher and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module ctae_fifo
    import ctae_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output      logic o_push_ready,
    input  wire t_cmd i_push_cmd,
    output      logic o_pop_valid,
    input  wire logic i_pop_ready,
    output      t_cmd o_pop_cmd
);

    t_cmd       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_cmd    = r_slot[r_rptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wptr] <= i_push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### sv/ctae_back.sv
// ----------------------------------------------------------------------------
// ctae_back
// Emitter: walks each command byte by byte into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ctae_back
    import ctae_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_valid,
    output      logic       o_q_ready,
    input  wire t_cmd       i_q_cmd,
    output      logic       o_m_tvalid,
    input  wire logic       i_m_tready,
    output      logic [7:0] o_m_tdata,
    output      logic       o_m_tlast,
    output      logic       o_m_tuser
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_done;
    logic [3:0] r_idx;
    logic       w_load;
    logic       w_step;
    logic       w_final;
    logic [3:0] w_esc_pos;
    logic [7:0] w_byte;

    assign w_load    = !r_valid || i_m_tready;
    assign w_step    = w_load && i_q_valid;
    assign w_final   = (r_idx == i_q_cmd.last_idx);
    assign w_esc_pos = r_idx - i_q_cmd.prefix_len;
    assign o_q_ready = w_load && w_final;

    // Pick the byte at the current position of the command.
    always_comb begin
        if (r_idx < i_q_cmd.prefix_len) begin
            w_byte = tag_char(i_q_cmd.tag, r_idx);
        end else if (i_q_cmd.tail == TAIL_ESC) begin
            w_byte = esc_char(i_q_cmd.tag, w_esc_pos[2:0]);
        end else begin
            w_byte = i_q_cmd.tail_byte;
        end
    end

    // Position within the current command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 4'd0;
        end else if (w_step) begin
            r_idx <= w_final ? 4'd0 : r_idx + 4'd1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_byte <= w_byte;
            r_last <= w_final;
            r_done <= w_final && i_q_cmd.eos;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_byte;
    assign o_m_tuser  = r_last;
    assign o_m_tlast  = r_done;

endmodule

`default_nettype wire

### sv/colour_tag_to_ansi_escape.sv
// ----------------------------------------------------------------------------
// colour_tag_to_ansi_escape
// Replaces colour tags in a byte stream with ANSI escape sequences.
// ----------------------------------------------------------------------------
// One byte is taken per transfer on the slave side and one byte leaves per
// transfer on the master side. The input accepts a byte every cycle as long
// as the two-entry command queue between the tag matcher and the emitter has
// room; the output bytes that one input byte causes (0 to 9) leave the emitter
// one by one through the single output register, which holds them while the
// receiver is not ready. Bytes of a partly matched tag are held without
// output until the tag completes, fails, or the string ends.
`default_nettype none

`include "assert_macros.svh"

module colour_tag_to_ansi_escape
    import ctae_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output      logic       o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  wire logic       i_s_tlast,   // end_of_string
    output      logic       o_m_tvalid,
    input  wire logic       i_m_tready,
    output      logic [7:0] o_m_tdata,   // [7:0] out_byte
    output      logic       o_m_tlast,   // string_done
    output      logic       o_m_tuser    // [0] run_last
);

    logic w_push_valid;
    logic w_push_ready;
    t_cmd w_push_cmd;
    logic w_pop_valid;
    logic w_pop_ready;
    t_cmd w_pop_cmd;
    logic w_front_idle;

    // Tag matcher.
    ctae_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_q_valid  (w_push_valid),
        .i_q_ready  (w_push_ready),
        .o_q_cmd    (w_push_cmd),
        .o_idle     (w_front_idle)
    );

    // Command queue.
    ctae_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_cmd    (w_pop_cmd)
    );

    // Emitter.
    ctae_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_pop_valid),
        .o_q_ready  (w_pop_ready),
        .i_q_cmd    (w_pop_cmd),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // The end of a string always closes the run it belongs to.
    `ASSERT_CLK(a_done_is_run_last, i_clk, i_rst_n, (o_m_tvalid && o_m_tlast) |-> o_m_tuser)

    // A full queue always has a command to hand out.
    `ASSERT_CLK(a_full_not_empty, i_clk, i_rst_n, !w_push_ready |-> w_pop_valid)

    // After the final byte of a string no tag prefix stays held.
    `ASSERT_CLK(a_eos_clears_match, i_clk, i_rst_n,
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> w_front_idle)

endmodule

`default_nettype wire

### tb/sv/ctae_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ctae_checker
// Watches both stream channels of the colour tag converter, works out the
// bytes each input transfer should produce and compares every output transfer
// against the oldest byte still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module ctae_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    input  wire logic       i_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  wire logic       i_s_tlast,   // end_of_string
    input  wire logic       i_m_tvalid,
    input  wire logic       i_m_tready,
    input  wire logic [7:0] i_m_tdata,   // [7:0] out_byte
    input  wire logic       i_m_tlast,   // string_done
    input  wire logic       i_m_tuser,   // [0] run_last
    output int              o_errors,
    output int              o_pending,
    output int              o_bytes_in,
    output int              o_bytes_out,
    output int              o_tags_replaced
);

    localparam logic [7:0] LBRACE   = 8'h7B;
    localparam logic [7:0] ESC_CHAR = 8'h1B;
    localparam logic [7:0] LBRACKET = 8'h5B;
    localparam int         NUM_TAGS = 7;

    // One byte owed on the output side, with its two marker flags.
    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       string_done;
    } t_owed_byte;

    // Tag spellings and the tails of their escape sequences (after ESC '[').
    string tag_words [NUM_TAGS] = '{"{red}", "{green}", "{yellow}", "{blue}",
                                    "{magneta}", "{cyan}", "{eoc}"};
    string esc_tails [NUM_TAGS] = '{"31m", "32m", "33m", "34m", "35m", "36m", "0m"};

    t_owed_byte owed_q [$];
    logic [2:0] tag_sel;
    logic [3:0] match_len;
    int         err_count;
    int         in_count;
    int         out_count;
    int         tag_count;

    // Converter state update for one input byte; the bytes it releases go to
    // the back of the owed queue, the last one flagged.
    task automatic convert_byte(input logic [7:0] b, input logic eos);
        logic [7:0] run [$];
        string      w;
        int         t;
        int         hit;
        t_owed_byte ob;

        // A candidate beyond the tag table means nothing is held.
        if (match_len >= 4'd2 && tag_sel >= NUM_TAGS) match_len = 4'd0;

        if (match_len == 4'd0) begin
            if (b == LBRACE) match_len = 4'd1;
            else run.push_back(b);
        end else if (match_len == 4'd1) begin
            // The second byte alone picks the tag.
            hit = -1;
            for (t = 0; t < NUM_TAGS; t++) begin
                w = tag_words[t];
                if (hit < 0 && w[1] == b) hit = t;
            end
            if (hit >= 0) begin
                tag_sel   = hit[2:0];
                match_len = 4'd2;
            end else begin
                run.push_back(LBRACE);
                match_len = 4'd0;
                if (b == LBRACE) match_len = 4'd1;
                else run.push_back(b);
            end
        end else begin
            w = tag_words[tag_sel];
            if (match_len < w.len() && w[match_len] == b) begin
                match_len++;
                if (match_len == w.len()) begin
                    run.push_back(ESC_CHAR);
                    run.push_back(LBRACKET);
                    w = esc_tails[tag_sel];
                    for (t = 0; t < w.len(); t++) run.push_back(w[t]);
                    match_len = 4'd0;
                    tag_count++;
                end
            end else begin
                // Mismatch: release the held prefix, then take the byte afresh.
                for (t = 0; t < match_len; t++) run.push_back(w[t]);
                match_len = 4'd0;
                if (b == LBRACE) match_len = 4'd1;
                else run.push_back(b);
            end
        end

        // End of string flushes whatever prefix is still held.
        if (eos) begin
            if (match_len == 4'd1) begin
                run.push_back(LBRACE);
            end else if (match_len >= 4'd2 && tag_sel < NUM_TAGS) begin
                w = tag_words[tag_sel];
                for (t = 0; t < match_len; t++) run.push_back(w[t]);
            end
            match_len = 4'd0;
            tag_sel   = 3'd0;
        end

        for (t = 0; t < run.size(); t++) begin
            ob.ch          = run[t];
            ob.run_last    = (t == run.size() - 1);
            ob.string_done = (t == run.size() - 1) && eos;
            owed_q.push_back(ob);
        end
    endtask

    // Predict on input transfers, compare on output transfers.
    always @(posedge i_clk) begin
        t_owed_byte ob;
        if (!i_rst_n) begin
            owed_q.delete();
            tag_sel   = 3'd0;
            match_len = 4'd0;
            err_count = 0;
            in_count  = 0;
            out_count = 0;
            tag_count = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                convert_byte(i_s_tdata, i_s_tlast);
                in_count++;
            end
            if (i_m_tvalid && i_m_tready) begin
                out_count++;
                if (owed_q.size() == 0) begin
                    $error("unexpected output transfer: out_byte %02h", i_m_tdata);
                    err_count++;
                end else begin
                    ob = owed_q.pop_front();
                    if (i_m_tdata !== ob.ch) begin
                        $error("out_byte: expected %02h, got %02h", ob.ch, i_m_tdata);
                        err_count++;
                    end
                    if (i_m_tuser !== ob.run_last) begin
                        $error("run_last: expected %0b, got %0b", ob.run_last, i_m_tuser);
                        err_count++;
                    end
                    if (i_m_tlast !== ob.string_done) begin
                        $error("string_done: expected %0b, got %0b",
                               ob.string_done, i_m_tlast);
                        err_count++;
                    end
                end
            end
        end
        o_errors        <= err_count;
        o_pending       <= owed_q.size();
        o_bytes_in      <= in_count;
        o_bytes_out     <= out_count;
        o_tags_replaced <= tag_count;
    end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives strings through the colour tag converter: a short directed set of
// edge cases, then random strings mixing whole tags, cut-off and broken tag
// prefixes, stray braces and arbitrary bytes, under four flow-control phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    localparam logic [7:0] LBRACE = 8'h7B;
    localparam int RANDOM_ITEMS   = 360;
    localparam int PHASE_ITEMS    = RANDOM_ITEMS / 4;

    // Flow-control phases for the two sides.
    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_TX_IDLE,
        FLOW_RX_STALL,
        FLOW_BOTH
    } t_flow;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       s_tvalid   = 1'b0;
    logic [7:0] s_tdata    = 8'h00;
    logic       s_tlast    = 1'b0;
    logic       m_tready   = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;
    wire        m_tlast;
    wire        m_tuser;

    int         errors;
    int         pending;
    int         bytes_in;
    int         bytes_out;
    int         tags_replaced;
    int         strings_sent = 0;
    int         items_sent   = 0;
    t_flow      flow         = FLOW_FREE;
    logic [7:0] text_q [$];

    string tag_words [7] = '{"{red}", "{green}", "{yellow}", "{blue}",
                             "{magneta}", "{cyan}", "{eoc}"};

    colour_tag_to_ansi_escape dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    ctae_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tlast       (s_tlast),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tlast       (m_tlast),
        .i_m_tuser       (m_tuser),
        .o_errors        (errors),
        .o_pending       (pending),
        .o_bytes_in      (bytes_in),
        .o_bytes_out     (bytes_out),
        .o_tags_replaced (tags_replaced)
    );

    // 50 MHz clock.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Hang guard.
    initial begin
        #20_000_000;
        $display("tb_top failed");
        $finish;
    end

    function automatic int tx_idle_pct(input t_flow f);
        return (f == FLOW_TX_IDLE) ? 84 : (f == FLOW_BOTH) ? 8 : 0;
    endfunction

    function automatic int rx_stall_pct(input t_flow f);
        return (f == FLOW_RX_STALL) ? 84 : (f == FLOW_BOTH) ? 8 : 0;
    endfunction

    // The receiver decides each cycle whether it takes a byte.
    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct(flow));
    end

    task automatic add_word(input string w);
        int i;
        for (i = 0; i < w.len(); i++) text_q.push_back(w[i]);
    endtask

    // Sends the buffered text as one string, end marker on the final byte.
    // The valid line is left as it is at the end; the next string or the
    // caller decides when it drops.
    task automatic send_text();
        int i;
        for (i = 0; i < text_q.size(); i++) begin
            while ($urandom_range(99) < tx_idle_pct(flow)) begin
                s_tvalid <= 1'b0;
                @(negedge i_clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= text_q[i];
            s_tlast  <= (i == text_q.size() - 1);
            @(posedge i_clk);
            while (!s_tready) @(posedge i_clk);
            @(negedge i_clk);
            items_sent++;
        end
        text_q.delete();
        strings_sent++;
    endtask

    // A byte that may or may not continue a tag prefix.
    function automatic logic [7:0] stray_byte();
        int r;
        r = $urandom_range(3);
        if (r == 0) return LBRACE;
        if (r == 3) return 8'($urandom_range(255));
        return 8'($urandom_range(97, 122));
    endfunction

    // Random string: whole tags most often, with broken prefixes and noise mixed in.
    task automatic build_random_text();
        int    kind;
        int    cut;
        string w;
        repeat ($urandom_range(1, 8)) begin
            kind = $urandom_range(99);
            w    = tag_words[$urandom_range(6)];
            if (kind < 45) begin
                add_word(w);
            end else if (kind < 65) begin
                cut = $urandom_range(1, w.len() - 1);
                add_word(w.substr(0, cut - 1));
                if ($urandom_range(3) != 0) text_q.push_back(stray_byte());
            end else if (kind < 85) begin
                text_q.push_back(8'($urandom_range(255)));
            end else if (kind < 93) begin
                text_q.push_back(8'($urandom_range(32, 126)));
            end else begin
                text_q.push_back(LBRACE);
            end
        end
    endtask

    initial begin
        t_flow ph;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme bytes, a whole tag, a lone brace with a miss,
        // a brace restarting a match, tags cut short by the end of string,
        // and a mismatch deep inside a tag.
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        send_text();
        add_word("{red}");
        send_text();
        add_word("{q");
        send_text();
        add_word("{{eoc}");
        send_text();
        add_word("{mag");
        send_text();
        add_word("{");
        send_text();
        add_word("{cyaX");
        send_text();

        // Random strings, one flow-control phase after another.
        ph = FLOW_FREE;
        repeat (4) begin
            flow = ph;
            while (items_sent < PHASE_ITEMS * (int'(ph) + 1)) begin
                build_random_text();
                send_text();
            end
            ph = t_flow'(int'(ph) + 1);
        end
        flow = FLOW_FREE;
        s_tvalid <= 1'b0;

        // Drain, then keep watching the output for anything stray to show up.
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);

        $display("Sent %0d strings (%0d bytes) through all four flow-control phases.",
                 strings_sent, bytes_in);
        $display("Checked %0d output bytes, %0d tags replaced by escape sequences.",
                 bytes_out, tags_replaced);
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
